### sv/assert_macros.svh
// Assertion macros used by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds
`define WGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define WGA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/wga_pkg.sv
// ----------------------------------------------------------------------------
// wga_pkg
// Types, codes and sizes shared by the worker group allocator.
// ----------------------------------------------------------------------------
package wga_pkg;

	localparam int MAX_WORKERS = 16;
	localparam int IDX_W       = $clog2(MAX_WORKERS);
	localparam int PTR_W       = IDX_W + 1;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_WORKERS);

	// request actions
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_WAKE  = 2'd2;
	localparam logic [1:0] ACT_MARK  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_GROUP  = 3'd1;
	localparam logic [2:0] ST_NO_WORKER = 3'd2;
	localparam logic [2:0] ST_BAD_COUNT = 3'd3;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

	// group life cycle codes
	localparam logic [1:0] GS_IDLE = 2'd0;
	localparam logic [1:0] GS_BUSY = 2'd1;
	localparam logic [1:0] GS_DONE = 2'd2;

	// register index of the pool size
	localparam logic REG_WORKERS_IN_USE = 1'b0;

	typedef struct packed {
		logic [PTR_W-1:0] next_free;
		logic [PTR_W-1:0] first;
		logic [PTR_W-1:0] size;
		logic [1:0]       gstate;
	} grp_entry_t;

	typedef struct packed {
		logic             wr;
		logic [PTR_W-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] group_id;
		logic [IDX_W-1:0] worker_id;
		logic [IDX_W-1:0] member_pos;
		logic             member_valid;
		logic             last;
		logic             finished_found;
		logic [IDX_W-1:0] finished_group;
		logic [PTR_W-1:0] free_workers;
	} result_t;

endpackage

### sv/wga_ram.sv
// ----------------------------------------------------------------------------
// wga_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/wga_seq.sv
// ----------------------------------------------------------------------------
// wga_seq
// Sequencer: owns the free-list heads and walks the link memories.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wga_seq import wga_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_wr_t          cfg,
	output logic [PTR_W-1:0] pool_size,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	input  logic [4:0]       member_count,
	input  logic [3:0]       group_select,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_GRP  = 6'b000100,
		S_RD   = 6'b001000,
		S_MEM  = 6'b010000,
		S_RES  = 6'b100000
	} seq_state_t;

	seq_state_t       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [PTR_W-1:0] n_q, wh_q, gfh_q, fc_q, cur_q, size_q, cnt_q;
	logic [MAX_WORKERS-1:0] done_q;
	logic [1:0]       act_q;
	logic [IDX_W-1:0] gsel_q, grp_q, pos_q;
	logic [2:0]       rstat_q;

	logic             g_we, g_re, w_we, w_re;
	logic [IDX_W-1:0] g_addr, w_addr;
	grp_entry_t       g_wdata, g_rdata;
	logic [PTR_W-1:0] w_wdata, w_rdata;
	logic [PTR_W-1:0] chain, clr_ext;
	logic             last_m, ff_found;
	logic [IDX_W-1:0] ff_group;
	logic [2:0]       alloc_err;
	logic             grp_bad;

	wga_ram #(.WIDTH($bits(grp_entry_t)), .DEPTH(MAX_WORKERS)) u_grp_mem (
		.clk(clk), .we(g_we), .re(g_re), .addr(g_addr), .wdata(g_wdata), .rdata(g_rdata)
	);

	wga_ram #(.WIDTH(PTR_W), .DEPTH(MAX_WORKERS)) u_wrk_mem (
		.clk(clk), .we(w_we), .re(w_re), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata)
	);

	assign pool_size = n_q;
	assign in_stall  = (state_q != S_IDLE);

	// chain entry for the clearing pass
	assign clr_ext = {1'b0, clr_q} + PTR_W'(1);
	assign chain   = (clr_ext < n_q) ? clr_ext : NIL;

	assign last_m = ({1'b0, pos_q} + PTR_W'(1)) == size_q;

	// allocate checks, count first, then the pools
	always_comb begin
		if (cnt_q == '0 || cnt_q > n_q) begin
			alloc_err = ST_BAD_COUNT;
		end else if (gfh_q >= n_q) begin
			alloc_err = ST_NO_GROUP;
		end else if (cnt_q > fc_q) begin
			alloc_err = ST_NO_WORKER;
		end else begin
			alloc_err = ST_OK;
		end
	end

	assign grp_bad = ({1'b0, gsel_q} >= n_q) || (g_rdata.gstate == GS_IDLE);

	// lowest finished group
	always_comb begin
		ff_found = 1'b0;
		ff_group = '0;
		for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
			if (done_q[i]) begin
				ff_found = 1'b1;
				ff_group = IDX_W'(i);
			end
		end
	end

	// memory port control
	always_comb begin
		g_we    = 1'b0;
		g_re    = 1'b0;
		g_addr  = gsel_q;
		g_wdata = '{next_free: NIL, first: NIL, size: '0, gstate: GS_IDLE};
		w_we    = 1'b0;
		w_re    = 1'b0;
		w_addr  = cur_q[IDX_W-1:0];
		w_wdata = NIL;
		unique case (state_q)
			S_CLR: begin
				g_we    = 1'b1;
				g_addr  = clr_q;
				g_wdata = '{next_free: chain, first: NIL, size: '0, gstate: GS_IDLE};
				w_we    = 1'b1;
				w_addr  = clr_q;
				w_wdata = chain;
			end
			S_IDLE: begin
				g_re   = in_valid;
				g_addr = (action == ACT_ALLOC) ? gfh_q[IDX_W-1:0] : group_select;
			end
			S_GRP: begin
				if (act_q == ACT_ALLOC) begin
					g_addr  = gfh_q[IDX_W-1:0];
					g_we    = (alloc_err == ST_OK);
					g_wdata = '{next_free: NIL, first: wh_q, size: cnt_q, gstate: GS_BUSY};
				end else if (!grp_bad && act_q == ACT_MARK) begin
					g_we    = 1'b1;
					g_wdata = '{next_free: g_rdata.next_free, first: g_rdata.first,
						size: g_rdata.size, gstate: GS_DONE};
				end else if (!grp_bad && act_q == ACT_FREE) begin
					g_we    = 1'b1;
					g_wdata = '{next_free: gfh_q, first: NIL, size: '0, gstate: GS_IDLE};
				end
			end
			S_RD: begin
				w_re = 1'b1;
			end
			S_MEM: begin
				if (act_q == ACT_FREE) begin
					w_we    = 1'b1;
					w_wdata = wh_q;
				end else if (act_q == ACT_ALLOC) begin
					w_we    = last_m && res_ready;
					w_wdata = NIL;
				end
			end
			S_RES: begin
			end
			default: begin
			end
		endcase
	end

	// result towards the output register
	always_comb begin
		res.finished_found = ff_found;
		res.finished_group = ff_group;
		res.free_workers   = fc_q;
		res.group_id       = grp_q;
		if (state_q == S_MEM) begin
			res_valid        = (act_q != ACT_FREE);
			res.status       = ST_OK;
			res.worker_id    = cur_q[IDX_W-1:0];
			res.member_pos   = pos_q;
			res.member_valid = 1'b1;
			res.last         = last_m;
		end else begin
			res_valid        = (state_q == S_RES);
			res.status       = rstat_q;
			res.worker_id    = '0;
			res.member_pos   = '0;
			res.member_valid = 1'b0;
			res.last         = 1'b1;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			n_q     <= PTR_W'(MAX_WORKERS);
			wh_q    <= '0;
			gfh_q   <= '0;
			fc_q    <= PTR_W'(MAX_WORKERS);
			done_q  <= '0;
		end else if (cfg.wr) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			n_q     <= cfg.value;
			wh_q    <= '0;
			gfh_q   <= '0;
			fc_q    <= cfg.value;
			done_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_WORKERS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_GRP;
					end
				end
				S_GRP: begin
					if (act_q == ACT_ALLOC) begin
						if (alloc_err == ST_OK) begin
							gfh_q   <= g_rdata.next_free;
							fc_q    <= fc_q - cnt_q;
							state_q <= S_RD;
						end else begin
							state_q <= S_RES;
						end
					end else if (grp_bad) begin
						state_q <= S_RES;
					end else begin
						unique case (act_q)
							ACT_MARK: begin
								done_q[gsel_q] <= 1'b1;
								state_q        <= S_RES;
							end
							ACT_FREE: begin
								done_q[gsel_q] <= 1'b0;
								gfh_q          <= {1'b0, gsel_q};
								fc_q           <= fc_q + g_rdata.size;
								state_q        <= S_RD;
							end
							default: begin
								state_q <= S_RD;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_MEM;
				end
				S_MEM: begin
					if (act_q == ACT_FREE) begin
						wh_q    <= cur_q;
						state_q <= last_m ? S_RES : S_RD;
					end else if (res_ready) begin
						if (last_m && act_q == ACT_ALLOC) begin
							wh_q <= w_rdata;
						end
						state_q <= last_m ? S_IDLE : S_RD;
					end
				end
				S_RES: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and walk registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q  <= action;
			cnt_q  <= member_count;
			gsel_q <= group_select;
		end
		if (state_q == S_GRP) begin
			pos_q <= '0;
			if (act_q == ACT_ALLOC) begin
				rstat_q <= alloc_err;
				grp_q   <= (alloc_err == ST_OK) ? gfh_q[IDX_W-1:0] : '0;
				cur_q   <= wh_q;
				size_q  <= cnt_q;
			end else begin
				rstat_q <= grp_bad ? ST_NOT_ALLOC : ST_OK;
				grp_q   <= gsel_q;
				cur_q   <= g_rdata.first;
				size_q  <= g_rdata.size;
			end
		end
		if (state_q == S_MEM && (act_q == ACT_FREE || res_ready)) begin
			cur_q <= w_rdata;
			pos_q <= pos_q + IDX_W'(1);
		end
	end

	`WGA_ASSERT_IMP(a_fc_in_pool, clk, arst_n, 1'b1, fc_q <= n_q, "free count above pool size")
	`WGA_ASSERT_IMP(a_done_in_pool, clk, arst_n, 1'b1, (done_q >> n_q) == '0,
		"finished group outside pool")
	`WGA_ASSERT_IMP(a_head_matches_count, clk, arst_n, state_q == S_IDLE,
		(wh_q >= n_q) == (fc_q == '0), "worker head disagrees with free count")

endmodule

### sv/worker_group_allocator.sv
// ----------------------------------------------------------------------------
// worker_group_allocator
// Group and worker pool with two LIFO free lists held in link memories.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_stall   action, member_count, group_select
// out       output     out_valid/out_stall status .. free_workers
// cfg       input      APB (pready high)   workers_in_use at byte address 0
//
// An allocate or wake request passes S_GRP, then S_RD and S_MEM per member
// walked, S_RD waiting on the registered read of the worker link memory; a
// free walks alike, then S_RES; errors and mark-finished go on to S_RES.
// After reset and after each workers_in_use write a clearing pass over all
// 16 entries rebuilds both memories; no request is taken meanwhile.
// The output register lets a result wait under out_stall; the walk holds.
// ----------------------------------------------------------------------------
module worker_group_allocator import wga_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [4:0]  member_count,
	input  logic [3:0]  group_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  group_id,
	output logic [3:0]  worker_id,
	output logic [3:0]  member_pos,
	output logic        member_valid,
	output logic        last,
	output logic        finished_found,
	output logic [3:0]  finished_group,
	output logic [4:0]  free_workers
);

	cfg_wr_t          cfg;
	logic [PTR_W-1:0] pool_size, raw;
	logic             res_valid, res_ready, out_valid_q;
	result_t          res, out_q;

	assign pready = 1'b1;
	assign raw    = pwdata[PTR_W-1:0];

	// decode register write and clamp the pool size
	always_comb begin
		cfg.wr = psel && penable && pwrite && (paddr[2] == REG_WORKERS_IN_USE);
		if (raw == '0) begin
			cfg.value = PTR_W'(1);
		end else if (raw > PTR_W'(MAX_WORKERS)) begin
			cfg.value = PTR_W'(MAX_WORKERS);
		end else begin
			cfg.value = raw;
		end
	end

	assign prdata = (paddr[2] == REG_WORKERS_IN_USE) ? {{(32-PTR_W){1'b0}}, pool_size} : '0;

	wga_seq u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .pool_size(pool_size),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.member_count(member_count), .group_select(group_select),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// hold a result until the consumer takes it
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign group_id       = out_q.group_id;
	assign worker_id      = out_q.worker_id;
	assign member_pos     = out_q.member_pos;
	assign member_valid   = out_q.member_valid;
	assign last           = out_q.last;
	assign finished_found = out_q.finished_found;
	assign finished_group = out_q.finished_group;
	assign free_workers   = out_q.free_workers;

endmodule

### tb/worker_group_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// worker_group_allocator_tb
// Self-checking bench for the worker group allocator. A directed table of
// requests covers the error codes, the pool extremes and the group life
// cycle, then random requests run under several pool sizes. Every result is
// checked against an in-bench model of both free lists, with random sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module worker_group_allocator_tb;
	import wga_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RAND_PER_PHASE = 95;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [1:0]  action;
	logic [4:0]  member_count;
	logic [3:0]  group_select;
	logic        out_valid, out_stall;
	logic [2:0]  status;
	logic [3:0]  group_id, worker_id, member_pos;
	logic        member_valid, last, finished_found;
	logic [3:0]  finished_group;
	logic [4:0]  free_workers;

	worker_group_allocator dut (.*);

	// pool model
	int pool_size;
	int wk_next[MAX_WORKERS];
	int wk_head;
	int wk_free;
	int gp_next[MAX_WORKERS];
	int gp_head;
	int gp_first[MAX_WORKERS];
	int gp_size[MAX_WORKERS];
	logic [1:0] gp_state[MAX_WORKERS];

	result_t pending_results[$];
	int errors;
	int requests_sent;
	int results_seen;
	int idle_cycles;
	bit stall_on;

	typedef struct {
		logic [1:0] act;
		logic [4:0] cnt;
		logic [3:0] grp;
		bit         known;
		logic [2:0] want;
	} row_t;

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// rebuild the model for a new pool size
	function automatic void pool_rebuild(input logic [4:0] value);
		int v;
		v = value;
		if (v < 1) v = 1;
		if (v > MAX_WORKERS) v = MAX_WORKERS;
		pool_size = v;
		for (int i = 0; i < MAX_WORKERS; i++) begin
			wk_next[i] = (i + 1 < v) ? i + 1 : MAX_WORKERS;
			gp_next[i] = (i + 1 < v) ? i + 1 : MAX_WORKERS;
			gp_first[i] = MAX_WORKERS;
			gp_size[i] = 0;
			gp_state[i] = GS_IDLE;
		end
		wk_head = 0;
		gp_head = 0;
		wk_free = v;
	endfunction

	// work out the results of one request and queue them
	function automatic void pool_step(input logic [1:0] act, input logic [4:0] cnt,
			input logic [3:0] g);
		result_t batch[$];
		result_t r;
		int w, nxt, grp, prev, fg;
		bit found;
		r = '0;
		r.last = 1'b1;
		if (act == ACT_ALLOC) begin
			if (cnt == 0 || cnt > pool_size) begin
				r.status = ST_BAD_COUNT;
				batch.push_back(r);
			end else if (gp_head >= pool_size) begin
				r.status = ST_NO_GROUP;
				batch.push_back(r);
			end else if (cnt > wk_free) begin
				r.status = ST_NO_WORKER;
				batch.push_back(r);
			end else begin
				grp = gp_head;
				gp_head = gp_next[grp];
				gp_next[grp] = MAX_WORKERS;
				prev = MAX_WORKERS;
				for (int i = 0; i < cnt; i++) begin
					w = wk_head;
					wk_head = wk_next[w];
					wk_free--;
					wk_next[w] = MAX_WORKERS;
					if (prev == MAX_WORKERS) gp_first[grp] = w;
					else wk_next[prev] = w;
					prev = w;
					r.status = ST_OK;
					r.group_id = grp;
					r.worker_id = w;
					r.member_pos = i;
					r.member_valid = 1'b1;
					r.last = (i + 1 == cnt);
					batch.push_back(r);
				end
				gp_size[grp] = cnt;
				gp_state[grp] = GS_BUSY;
			end
		end else if (g >= pool_size || gp_state[g] == GS_IDLE) begin
			r.status = ST_NOT_ALLOC;
			r.group_id = g;
			batch.push_back(r);
		end else if (act == ACT_FREE) begin
			w = gp_first[g];
			for (int i = 0; i < gp_size[g]; i++) begin
				nxt = wk_next[w];
				wk_next[w] = wk_head;
				wk_head = w;
				wk_free++;
				w = nxt;
			end
			gp_first[g] = MAX_WORKERS;
			gp_size[g] = 0;
			gp_state[g] = GS_IDLE;
			gp_next[g] = gp_head;
			gp_head = g;
			r.group_id = g;
			batch.push_back(r);
		end else if (act == ACT_WAKE) begin
			w = gp_first[g];
			for (int i = 0; i < gp_size[g]; i++) begin
				r.group_id = g;
				r.worker_id = w;
				r.member_pos = i;
				r.member_valid = 1'b1;
				r.last = (i + 1 == gp_size[g]);
				batch.push_back(r);
				w = wk_next[w];
			end
		end else begin
			gp_state[g] = GS_DONE;
			r.group_id = g;
			batch.push_back(r);
		end
		// report the lowest finished group and the free count after the step
		found = 1'b0;
		fg = 0;
		for (int i = 0; i < pool_size; i++) begin
			if (!found && gp_state[i] == GS_DONE) begin
				found = 1'b1;
				fg = i;
			end
		end
		foreach (batch[k]) begin
			batch[k].finished_found = found;
			batch[k].finished_group = fg;
			batch[k].free_workers = wk_free;
			pending_results.push_back(batch[k]);
		end
	endfunction

	// hold a request until accepted, then predict it
	task automatic send_request(input logic [1:0] act, input logic [4:0] cnt,
			input logic [3:0] g, input bit known, input logic [2:0] want);
		int first;
		in_valid <= 1'b1;
		action <= act;
		member_count <= cnt;
		group_select <= g;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		first = pending_results.size();
		pool_step(act, cnt, g);
		requests_sent++;
		if (known && pending_results[first].status !== want) begin
			$display("%0t: table status mismatch expected %0d actual %0d", $time,
				want, pending_results[first].status);
			errors++;
		end
	endtask

	// drop valid for a random gap between bursts
	task automatic sender_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for the block to go idle, then write the pool size
	task automatic write_pool_size(input logic [31:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_WORKERS_IN_USE);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pool_rebuild(value[4:0]);
	endtask

	// random request, mostly aimed at groups in use
	task automatic random_request();
		logic [1:0] act;
		logic [4:0] cnt;
		logic [3:0] g;
		int used[$];
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) act = ACT_ALLOC;
		else if (pick < 65) act = ACT_FREE;
		else if (pick < 85) act = ACT_WAKE;
		else act = ACT_MARK;
		if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, 31);
		else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(1, pool_size);
		else cnt = $urandom_range(1, (pool_size + 3) / 4);
		for (int i = 0; i < pool_size; i++)
			if (gp_state[i] != GS_IDLE) used.push_back(i);
		if (used.size() != 0 && $urandom_range(0, 9) < 8)
			g = used[$urandom_range(0, used.size() - 1)];
		else
			g = $urandom_range(0, 15);
		send_request(act, cnt, g, 1'b0, ST_OK);
	endtask

	// receiver: check each result, stall on a pattern of its own
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				got = '{status, group_id, worker_id, member_pos, member_valid, last,
					finished_found, finished_group, free_workers};
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result actual %p", $time, got);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch expected %p actual %p", $time,
							want, got);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
			out_stall <= stall_on && ($urandom_range(0, 2) == 0);
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				pending_results.size());
			$display("worker_group_allocator_tb failed");
			$finish;
		end
	end

	initial begin
		row_t full_pool[] = '{
			'{ACT_ALLOC, 5'd0, 4'd0, 1'b1, ST_BAD_COUNT},
			'{ACT_ALLOC, 5'd17, 4'd0, 1'b1, ST_BAD_COUNT},
			'{ACT_ALLOC, 5'd31, 4'd0, 1'b1, ST_BAD_COUNT},
			'{ACT_FREE, 5'd0, 4'd3, 1'b1, ST_NOT_ALLOC},
			'{ACT_WAKE, 5'd0, 4'd5, 1'b1, ST_NOT_ALLOC},
			'{ACT_MARK, 5'd0, 4'd15, 1'b1, ST_NOT_ALLOC},
			'{ACT_ALLOC, 5'd16, 4'd0, 1'b1, ST_OK},
			'{ACT_ALLOC, 5'd1, 4'd0, 1'b1, ST_NO_WORKER},
			'{ACT_WAKE, 5'd0, 4'd0, 1'b0, ST_OK},
			'{ACT_MARK, 5'd0, 4'd0, 1'b1, ST_OK},
			'{ACT_MARK, 5'd0, 4'd0, 1'b1, ST_OK},
			'{ACT_WAKE, 5'd0, 4'd0, 1'b0, ST_OK},
			'{ACT_FREE, 5'd0, 4'd0, 1'b1, ST_OK},
			'{ACT_ALLOC, 5'd3, 4'd0, 1'b0, ST_OK},
			'{ACT_ALLOC, 5'd13, 4'd0, 1'b0, ST_OK},
			'{ACT_MARK, 5'd0, 4'd1, 1'b0, ST_OK},
			'{ACT_FREE, 5'd0, 4'd0, 1'b0, ST_OK},
			'{ACT_WAKE, 5'd0, 4'd1, 1'b0, ST_OK}
		};
		row_t one_pool[] = '{
			'{ACT_ALLOC, 5'd2, 4'd0, 1'b1, ST_BAD_COUNT},
			'{ACT_ALLOC, 5'd1, 4'd0, 1'b1, ST_OK},
			'{ACT_ALLOC, 5'd1, 4'd0, 1'b1, ST_NO_GROUP},
			'{ACT_WAKE, 5'd0, 4'd1, 1'b1, ST_NOT_ALLOC},
			'{ACT_MARK, 5'd0, 4'd0, 1'b1, ST_OK},
			'{ACT_FREE, 5'd0, 4'd0, 1'b1, ST_OK}
		};
		int sizes[4];

		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = ACT_ALLOC;
		member_count = '0;
		group_select = '0;
		out_stall = 1'b0;
		stall_on = 1'b0;
		errors = 0;
		requests_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		pool_rebuild(5'd16);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table on the full pool after reset
		foreach (full_pool[i])
			send_request(full_pool[i].act, full_pool[i].cnt, full_pool[i].grp,
				full_pool[i].known, full_pool[i].want);

		// zero clamps to a single worker and group
		write_pool_size(32'd0);
		foreach (one_pool[i])
			send_request(one_pool[i].act, one_pool[i].cnt, one_pool[i].grp,
				one_pool[i].known, one_pool[i].want);

		// random phases over several pool sizes, 31 clamps to the maximum
		sizes = '{31, $urandom_range(3, 15), 2, 16};
		foreach (sizes[p]) begin
			write_pool_size(sizes[p]);
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (i == RAND_PER_PHASE / 2) begin
					// hold off until every result is back
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_results.size() != 0) @(posedge clk);
				end else if ($urandom_range(0, 5) == 0) begin
					sender_gap();
				end
				random_request();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d results over pool sizes 16, 1, 2 and one",
			requests_sent, results_seen);
		$display("random size, with sender gaps and receiver stalls; %0d errors", errors);
		if (errors == 0) begin
			$display("worker_group_allocator_tb passed");
		end else begin
			$display("worker_group_allocator_tb failed");
		end
		$finish;
	end

endmodule

### worker_group_allocator.f
+incdir+sv
sv/wga_pkg.sv
sv/wga_ram.sv
sv/wga_seq.sv
sv/worker_group_allocator.sv
tb/worker_group_allocator_tb.sv
